### hdl/afr_pkg.sv
// ----------------------------------------------------------------------------
// Addressed frame receiver package
// Shared widths, register indexes, frame phases and the delivery request type.
// ----------------------------------------------------------------------------
package afr_pkg;

  localparam int unsigned MaxPayload = 64;
  localparam int unsigned AddrW      = $clog2(MaxPayload);
  localparam int unsigned CountW     = $clog2(MaxPayload + 1);

  localparam int unsigned ByteW      = 8;
  localparam int unsigned StationW   = 16;
  localparam int unsigned IndexW     = 6;
  localparam int unsigned LengthW    = 7;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgOwnAddress = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStartMark  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgEndMark    = 2'd2;

  localparam logic [ByteW-1:0] StartMarkReset = 8'h02;
  localparam logic [ByteW-1:0] EndMarkReset   = 8'h03;

  typedef enum logic [6:0] {
    PhHunt  = 7'b0000001,
    PhAddrL = 7'b0000010,
    PhAddrH = 7'b0000100,
    PhLen   = 7'b0001000,
    PhData  = 7'b0010000,
    PhChk   = 7'b0100000,
    PhEnd   = 7'b1000000
  } phase_e;

  // Request from the frame parser to the payload emitter.
  typedef struct packed {
    logic              start;
    logic [CountW-1:0] count;
  } emit_req_t;

endpackage

### hdl/afr_if.sv
// ----------------------------------------------------------------------------
// Addressed frame receiver channels
// Valid/ready channels for received bytes, delivered payload and register writes.
// ----------------------------------------------------------------------------
interface afr_rx_if import afr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface afr_res_if import afr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ByteW-1:0]   payload_byte;
  logic [IndexW-1:0]  byte_index;
  logic [LengthW-1:0] frame_length;
  logic               last;

  modport source (output valid, output payload_byte, output byte_index,
                  output frame_length, output last, input ready);
  modport sink (input valid, input payload_byte, input byte_index,
                input frame_length, input last, output ready);
endinterface

interface afr_cfg_if import afr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

### hdl/afr_ram.sv
// ----------------------------------------------------------------------------
// Addressed frame receiver payload RAM
// Single-port-write, single-port-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module afr_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hdl/afr_parser.sv
// ----------------------------------------------------------------------------
// Addressed frame receiver parser
// Frame phase machine, configuration registers, checksum and payload writes.
// ----------------------------------------------------------------------------
module afr_parser import afr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  afr_rx_if.sink             rx,
  afr_cfg_if.sink            cfg,
  input  logic               emit_busy_i,
  output emit_req_t          emit_req_o,
  output logic               wr_en_o,
  output logic [AddrW-1:0]   wr_addr_o,
  output logic [ByteW-1:0]   wr_data_o
);

  phase_e              phase_q, phase_d;
  logic [ByteW-1:0]    addr_low_q, addr_low_d;
  logic [LengthW-1:0]  exp_len_q, exp_len_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [ByteW-1:0]    sum_q, sum_d;
  logic [StationW-1:0] own_addr_q;
  logic [ByteW-1:0]    start_mark_q;
  logic [ByteW-1:0]    end_mark_q;
  logic                take;
  logic [ByteW-1:0]    b;

  assign cfg.ready = 1'b1;
  assign rx.ready  = !emit_busy_i;
  assign take      = rx.valid && rx.ready;
  assign b         = rx.rx_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q   <= '0;
      start_mark_q <= StartMarkReset;
      end_mark_q   <= EndMarkReset;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CfgOwnAddress: own_addr_q   <= cfg.wdata;
        CfgStartMark:  start_mark_q <= cfg.wdata[ByteW-1:0];
        CfgEndMark:    end_mark_q   <= cfg.wdata[ByteW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d          = phase_q;
    addr_low_d       = addr_low_q;
    exp_len_d        = exp_len_q;
    count_d          = count_q;
    sum_d            = sum_q;
    wr_en_o          = 1'b0;
    emit_req_o.start = 1'b0;
    emit_req_o.count = count_q;
    if (take) begin
      unique case (phase_q)
        PhAddrL: begin
          addr_low_d = b;
          phase_d    = PhAddrH;
        end
        PhAddrH: begin
          if ({b, addr_low_q} == own_addr_q) begin
            sum_d   = own_addr_q[ByteW-1:0];
            count_d = '0;
            phase_d = PhLen;
          end else begin
            phase_d = PhHunt;
          end
          addr_low_d = '0;
        end
        PhLen: begin
          exp_len_d = b[LengthW-1:0];
          count_d   = '0;
          if (b > ByteW'(MaxPayload)) begin
            phase_d = PhHunt;
          end else if (b == '0) begin
            phase_d = PhChk;
          end else begin
            phase_d = PhData;
          end
        end
        PhData: begin
          wr_en_o = 1'b1;
          sum_d   = sum_q + b;
          count_d = count_q + 1'b1;
          if (count_d >= exp_len_q) begin
            phase_d = PhChk;
          end
        end
        PhChk: begin
          phase_d = (b == sum_q) ? PhEnd : PhHunt;
        end
        PhEnd: begin
          emit_req_o.start = (b == end_mark_q);
          phase_d          = PhHunt;
        end
        default: begin
          phase_d = (b == start_mark_q) ? PhAddrL : PhHunt;
        end
      endcase
    end
  end

  assign wr_addr_o = count_q[AddrW-1:0];
  assign wr_data_o = b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHunt;
      addr_low_q <= '0;
      exp_len_q  <= '0;
      count_q    <= '0;
      sum_q      <= '0;
    end else begin
      phase_q    <= phase_d;
      addr_low_q <= addr_low_d;
      exp_len_q  <= exp_len_d;
      count_q    <= count_d;
      sum_q      <= sum_d;
    end
  end

endmodule

### hdl/afr_emitter.sv
// ----------------------------------------------------------------------------
// Addressed frame receiver emitter
// Walks the payload RAM of a validated frame and drives the result register.
// ----------------------------------------------------------------------------
module afr_emitter import afr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  emit_req_t        emit_req_i,
  output logic             busy_o,
  output logic             rd_en_o,
  output logic [AddrW-1:0] rd_addr_o,
  input  logic [ByteW-1:0] rd_data_i,
  afr_res_if.source        res
);

  logic               busy_q, busy_d;
  logic [CountW-1:0]  rd_idx_q, rd_idx_d;
  logic [CountW-1:0]  total_q, total_d;
  logic               pend_q, pend_d;
  logic [IndexW-1:0]  pend_idx_q, pend_idx_d;
  logic               pend_last_q, pend_last_d;
  logic               pend_zero_q, pend_zero_d;
  logic               out_valid_q, out_valid_d;
  logic [ByteW-1:0]   out_byte_q, out_byte_d;
  logic [IndexW-1:0]  out_idx_q, out_idx_d;
  logic [LengthW-1:0] out_len_q, out_len_d;
  logic               out_last_q, out_last_d;
  logic               load;
  logic               issue;
  logic [CountW-1:0]  rd_idx_inc;

  // The RAM read data register doubles as the pending stage: it holds while
  // the result register is stalled because no new read is issued.
  assign load       = pend_q && (!out_valid_q || res.ready);
  assign issue      = busy_q && (rd_idx_q < total_q) && (!pend_q || load);
  assign rd_idx_inc = rd_idx_q + 1'b1;
  assign rd_en_o    = issue;
  assign rd_addr_o  = rd_idx_q[AddrW-1:0];
  assign busy_o     = busy_q;

  always_comb begin
    busy_d      = busy_q;
    rd_idx_d    = rd_idx_q;
    total_d     = total_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    pend_last_d = pend_last_q;
    pend_zero_d = pend_zero_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_idx_d   = out_idx_q;
    out_len_d   = out_len_q;
    out_last_d  = out_last_q;

    if (load) begin
      out_valid_d = 1'b1;
      out_byte_d  = pend_zero_q ? '0 : rd_data_i;
      out_idx_d   = pend_idx_q;
      out_len_d   = LengthW'(total_q);
      out_last_d  = pend_last_q;
      pend_d      = 1'b0;
    end else if (res.ready) begin
      out_valid_d = 1'b0;
    end

    if (issue) begin
      pend_d      = 1'b1;
      pend_idx_d  = rd_idx_q[IndexW-1:0];
      pend_last_d = (rd_idx_inc == total_q);
      pend_zero_d = 1'b0;
      rd_idx_d    = rd_idx_inc;
    end else if (busy_q && (rd_idx_q == total_q) && !pend_d) begin
      busy_d = 1'b0;
    end

    // An empty frame still yields one result, taken straight from the
    // pending stage with a zero payload byte.
    if (emit_req_i.start) begin
      busy_d   = 1'b1;
      rd_idx_d = '0;
      total_d  = emit_req_i.count;
      if (emit_req_i.count == '0) begin
        pend_d      = 1'b1;
        pend_idx_d  = '0;
        pend_last_d = 1'b1;
        pend_zero_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rd_idx_q    <= '0;
      total_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      rd_idx_q    <= rd_idx_d;
      total_q     <= total_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q  <= pend_idx_d;
    pend_last_q <= pend_last_d;
    pend_zero_q <= pend_zero_d;
    out_byte_q  <= out_byte_d;
    out_idx_q   <= out_idx_d;
    out_len_q   <= out_len_d;
    out_last_q  <= out_last_d;
  end

  assign res.valid        = out_valid_q;
  assign res.payload_byte = out_byte_q;
  assign res.byte_index   = out_idx_q;
  assign res.frame_length = out_len_q;
  assign res.last         = out_last_q;

endmodule

### hdl/addressed_frame_receiver.sv
// ----------------------------------------------------------------------------
// Addressed frame receiver
// Parses start/address/length/payload/checksum/end frames and emits payloads.
// ----------------------------------------------------------------------------
// Usage:
//   rx_i carries one received byte per transfer. The parser takes one byte
//   per cycle while no frame is being delivered. cfg_i writes own_address
//   (index 0), start_marker (index 1) and end_marker (index 2); it is always
//   ready and should only be written while the block is idle.
//   Payload bytes are stored in a 64-entry RAM as they arrive. When a frame
//   closes with the right checksum and end byte, the emitter reads the RAM
//   back and presents one result per payload byte on res_o, the final one
//   with last set; an empty frame gives a single result with length 0.
//   The first result appears after the end byte transfer, once its RAM read has
//   passed the read data register into the result register; then one result
//   per cycle follows while res_o is ready, limited by the single RAM read
//   port. rx_i is held not ready from the cycle after the end byte until the
//   last RAM read has moved into the result register. When res_o stalls, the
//   RAM read data and the result register hold and no new read is issued, so
//   nothing is lost. Reset returns the parser to hunting for a start byte,
//   restores the register defaults and drops any result in flight; the RAM
//   is not cleared.
// ----------------------------------------------------------------------------
module addressed_frame_receiver import afr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  afr_rx_if.sink    rx_i,
  afr_cfg_if.sink   cfg_i,
  afr_res_if.source res_o
);

  emit_req_t        emit_req;
  logic             emit_busy;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [ByteW-1:0] wr_data;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [ByteW-1:0] rd_data;

  afr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx          (rx_i),
    .cfg         (cfg_i),
    .emit_busy_i (emit_busy),
    .emit_req_o  (emit_req),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  afr_ram #(
    .Depth (MaxPayload),
    .Width (ByteW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  afr_emitter u_emitter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .emit_req_i (emit_req),
    .busy_o     (emit_busy),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .res        (res_o)
  );

endmodule

### tb/addressed_frame_receiver_test.sv
// ----------------------------------------------------------------------------
// Addressed frame receiver testbench
// Sends framed byte streams (good, truncated, corrupted and noise) under
// several register settings with random idling on both channels. An internal
// frame parser predicts every delivered payload byte, and each result is
// checked in order against that prediction.
// ----------------------------------------------------------------------------
module addressed_frame_receiver_test;
  import afr_pkg::*;

  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned ReportLimit  = 10;

  typedef logic [ByteW-1:0] octet_q_t[$];

  typedef struct packed {
    logic [ByteW-1:0]   payload_byte;
    logic [IndexW-1:0]  byte_index;
    logic [LengthW-1:0] frame_length;
    logic               last;
  } payload_result_t;

  typedef enum int {
    FrameIntact,
    FrameBadChecksum,
    FrameBadEnd
  } frame_flaw_e;

  logic clk = 1'b0;
  logic rst_n;

  afr_rx_if  rx ();
  afr_cfg_if cfg ();
  afr_res_if res ();

  addressed_frame_receiver u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx_i   (rx),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always #5 clk = ~clk;

  // Register shadows and frame parser state.
  logic [StationW-1:0] own_address;
  logic [ByteW-1:0]    start_mark;
  logic [ByteW-1:0]    end_mark;
  phase_e              parse_phase;
  logic [ByteW-1:0]    addr_low;
  logic [ByteW-1:0]    frame_len_field;
  logic [LengthW-1:0]  stored_count;
  logic [ByteW-1:0]    checksum_acc;
  logic [ByteW-1:0]    payload_mem[MaxPayload];

  payload_result_t expected_results[$];
  payload_result_t want_result;

  int unsigned mismatches       = 0;
  int unsigned results_checked  = 0;
  int unsigned bytes_sent       = 0;
  int unsigned frames_delivered = 0;
  int unsigned settings_applied = 0;
  int unsigned cycle_count      = 0;

  bit          no_gaps      = 1'b0;
  int unsigned hold_request = 0;
  int unsigned hold_left    = 0;
  int unsigned stall_left   = 0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 8);
    if (r < 95) return $urandom_range(9, 24);
    return $urandom_range(25, MaxPayload);
  endfunction

  // Random payload with marker values mixed in now and then.
  function automatic octet_q_t random_payload(int unsigned n);
    octet_q_t q;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: q.push_back(start_mark);
        1: q.push_back(end_mark);
        default: q.push_back(ByteW'($urandom));
      endcase
    end
    return q;
  endfunction

  function automatic void report_mismatch(string msg);
    mismatches++;
    if (mismatches <= ReportLimit) $display("mismatch: %s", msg);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      report_mismatch($sformatf("result %0d: %s expected %0h, got %0h",
                                results_checked, name, want, got));
    end
  endfunction

  // Frame parser: advances on every accepted byte and queues the payload
  // burst that a correctly closed frame delivers.
  task automatic parse_byte(input logic [ByteW-1:0] b);
    payload_result_t r;
    case (parse_phase)
      PhAddrL: begin
        addr_low    = b;
        parse_phase = PhAddrH;
      end
      PhAddrH: begin
        if ({b, addr_low} == own_address) begin
          checksum_acc = own_address[ByteW-1:0];
          stored_count = '0;
          parse_phase  = PhLen;
        end else begin
          parse_phase = PhHunt;
        end
        addr_low = '0;
      end
      PhLen: begin
        frame_len_field = b;
        stored_count    = '0;
        if (b > MaxPayload) parse_phase = PhHunt;
        else if (b == 0) parse_phase = PhChk;
        else parse_phase = PhData;
      end
      PhData: begin
        if (stored_count < MaxPayload && stored_count < frame_len_field) begin
          payload_mem[stored_count[AddrW-1:0]] = b;
          checksum_acc = checksum_acc + b;
          stored_count++;
        end
        if (stored_count >= frame_len_field) parse_phase = PhChk;
      end
      PhChk: begin
        parse_phase = (b == checksum_acc) ? PhEnd : PhHunt;
      end
      PhEnd: begin
        if (b == end_mark) begin
          frames_delivered++;
          if (stored_count == 0) begin
            r = '{payload_byte: '0, byte_index: '0, frame_length: '0, last: 1'b1};
            expected_results.push_back(r);
          end else begin
            for (int k = 0; k < stored_count; k++) begin
              r.payload_byte = payload_mem[AddrW'(k)];
              r.byte_index   = IndexW'(k);
              r.frame_length = stored_count;
              r.last         = (k == stored_count - 1);
              expected_results.push_back(r);
            end
          end
        end
        parse_phase = PhHunt;
      end
      default: begin
        parse_phase = (b == start_mark) ? PhAddrL : PhHunt;
      end
    endcase
  endtask

  // Offers one byte after a random gap and returns at the accepting edge.
  // valid is left high so that a following byte can go out back to back.
  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      rx.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk); while (!rx.ready);
    parse_byte(b);
    bytes_sent++;
  endtask

  task automatic rx_stop();
    @(negedge clk);
    rx.valid <= 1'b0;
  endtask

  // Stops sending and waits until every predicted result has been checked.
  task automatic wait_idle();
    rx_stop();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.wdata <= value;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      CfgOwnAddress: own_address = value;
      CfgStartMark:  start_mark  = value[ByteW-1:0];
      CfgEndMark:    end_mark    = value[ByteW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Sends a frame shaped by the arguments. A foreign address or an oversized
  // length ends the frame early, since the block drops it right there.
  task automatic send_frame(input logic [StationW-1:0] station, input logic [ByteW-1:0] len,
                            input octet_q_t payload, input frame_flaw_e flaw);
    logic [ByteW-1:0] sum;
    // Noise can leave the parser inside a frame; push it back to hunting first.
    while (parse_phase != PhHunt) send_byte(ByteW'($urandom));
    sum = own_address[ByteW-1:0];
    send_byte(start_mark);
    send_byte(station[7:0]);
    send_byte(station[15:8]);
    if (station != own_address) return;
    send_byte(len);
    if (len > MaxPayload) return;
    foreach (payload[i]) begin
      send_byte(payload[i]);
      sum = sum + payload[i];
    end
    if (flaw == FrameBadChecksum) begin
      send_byte(sum + ByteW'($urandom_range(1, 255)));
      return;
    end
    send_byte(sum);
    if (flaw == FrameBadEnd) send_byte(end_mark ^ ByteW'($urandom_range(1, 255)));
    else send_byte(end_mark);
  endtask

  task automatic random_frame();
    int unsigned pick;
    int unsigned len;
    no_gaps = ($urandom_range(0, 4) == 0);
    pick = $urandom_range(0, 99);
    len  = pick_length();
    if (pick < 72) begin
      send_frame(own_address, ByteW'(len), random_payload(len), FrameIntact);
    end else if (pick < 78) begin
      repeat ($urandom_range(1, 6)) send_byte(ByteW'($urandom));
    end else if (pick < 84) begin
      send_frame(own_address ^ StationW'($urandom_range(1, 65535)), ByteW'(len),
                 random_payload(len), FrameIntact);
    end else if (pick < 88) begin
      send_frame(own_address, ByteW'($urandom_range(MaxPayload + 1, 255)),
                 random_payload(0), FrameIntact);
    end else if (pick < 94) begin
      send_frame(own_address, ByteW'(len), random_payload(len), FrameBadChecksum);
    end else begin
      send_frame(own_address, ByteW'(len), random_payload(len), FrameBadEnd);
    end
  endtask

  task automatic set_registers(input logic [StationW-1:0] station,
                               input logic [ByteW-1:0] opener, input logic [ByteW-1:0] closer);
    wait_idle();
    write_reg(CfgOwnAddress, station);
    write_reg(CfgStartMark, CfgDataW'(opener));
    write_reg(CfgEndMark, CfgDataW'(closer));
    settings_applied++;
  endtask

  // Reset register values: empty frame, markers as data, and each way a
  // frame gets dropped.
  task automatic test_directed_frames();
    octet_q_t data;
    data = {};
    send_frame(own_address, 8'd0, data, FrameIntact);
    data = {end_mark, start_mark};
    send_frame(own_address, 8'd2, data, FrameIntact);
    send_frame(16'h0100, 8'd2, data, FrameIntact);
    send_frame(own_address, ByteW'(MaxPayload + 1), data, FrameIntact);
    data = {};
    send_frame(own_address, 8'd0, data, FrameBadChecksum);
    data = {8'hFF};
    send_frame(own_address, 8'd1, data, FrameBadEnd);
    wait_idle();
  endtask

  // Random traffic under extreme and random register values.
  task automatic test_register_settings();
    int unsigned first_byte;
    for (int s = 0; s < 4; s++) begin
      case (s)
        0: set_registers(16'hFFFF, 8'h00, 8'hFF);
        1: set_registers(16'h0000, 8'hFF, 8'h00);
        2: set_registers(16'h5AA5, 8'h7E, 8'h81);
        default: set_registers(StationW'($urandom), ByteW'($urandom), ByteW'($urandom));
      endcase
      first_byte = bytes_sent;
      while (bytes_sent - first_byte < 50) random_frame();
    end
  endtask

  // The receiver stalls for a long stretch while a full-size frame and two
  // more follow back to back, so the block has to hold off its input.
  task automatic test_backpressure();
    octet_q_t data;
    no_gaps = 1'b1;
    hold_request = 400;
    data = random_payload(MaxPayload);
    data[0] = 8'h00;
    data[MaxPayload-1] = 8'hFF;
    send_frame(own_address, ByteW'(MaxPayload), data, FrameIntact);
    send_frame(own_address, 8'd5, random_payload(5), FrameIntact);
    send_frame(own_address, 8'd0, random_payload(0), FrameIntact);
    wait_idle();
    no_gaps = 1'b0;
    send_frame(own_address, 8'd3, random_payload(3), FrameIntact);
  endtask

  // Result receiver: random stalls, plus a long hold when one is requested.
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      res.ready <= 1'b0;
      hold_left--;
    end else if (stall_left != 0) begin
      res.ready <= 1'b0;
      stall_left--;
    end else begin
      res.ready <= 1'b1;
      if (!no_gaps && $urandom_range(0, 2) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && res.valid && res.ready) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result: byte %0h index %0d length %0d last %0b",
                                  res.payload_byte, res.byte_index, res.frame_length,
                                  res.last));
      end else begin
        want_result = expected_results.pop_front();
        check_field("payload_byte", 32'(want_result.payload_byte), 32'(res.payload_byte));
        check_field("byte_index", 32'(want_result.byte_index), 32'(res.byte_index));
        check_field("frame_length", 32'(want_result.frame_length), 32'(res.frame_length));
        check_field("last", 32'(want_result.last), 32'(res.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("FAIL addressed_frame_receiver");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    rx.valid    = 1'b0;
    rx.rx_byte  = '0;
    cfg.valid   = 1'b0;
    cfg.index   = CfgOwnAddress;
    cfg.wdata   = '0;
    res.ready   = 1'b0;
    own_address = '0;
    start_mark  = StartMarkReset;
    end_mark    = EndMarkReset;
    parse_phase = PhHunt;
    addr_low        = '0;
    frame_len_field = '0;
    stored_count    = '0;
    checksum_acc    = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_frames();
    test_register_settings();
    test_backpressure();
    wait_idle();
    repeat (20) @(posedge clk);

    $display("Run covered %0d received bytes under %0d register settings plus reset values.",
             bytes_sent, settings_applied);
    $display("%0d frames delivered, %0d payload results checked, %0d mismatches.",
             frames_delivered, results_checked, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS addressed_frame_receiver");
    end else begin
      $display("FAIL addressed_frame_receiver");
    end
    $finish;
  end

endmodule
